[hdl/seed_color_threshold_mask_defines.svh]
// ---------------------------------------------------------------------------
// Seed color threshold mask: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SEED_COLOR_THRESHOLD_MASK_DEFINES_SVH
`define SEED_COLOR_THRESHOLD_MASK_DEFINES_SVH

// same-cycle implication
`define SCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/scm_pkg.sv]
// ---------------------------------------------------------------------------
// Seed color threshold mask: package
// Field widths, register indexes and reset constants.
// ---------------------------------------------------------------------------
package scm_pkg;

    localparam int COORD_W = 12;
    localparam int PIX_W   = 8;
    localparam int SUM_W   = 15;
    localparam int CNT_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // hard ceiling on the gathered pixel count (7-bit counter)
    localparam int COUNT_LIMIT = 127;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // register indexes
    localparam cfg_idx_t CFG_SEED_COL  = 2'd0;
    localparam cfg_idx_t CFG_SEED_ROW  = 2'd1;
    localparam cfg_idx_t CFG_THRESHOLD = 2'd2;

    localparam pix_t THRESHOLD_RESET = 8'd50;

    // item kinds
    localparam logic KIND_GATHER   = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;

    // window statistics
    typedef struct packed {
        sum_t blue;
        sum_t green;
        sum_t red;
        cnt_t count;
    } win_stats_t;

endpackage

[hdl/scm_chan_check.sv]
// ---------------------------------------------------------------------------
// Seed color threshold mask: channel check
// One channel: |pix*count - sum| <= threshold*count, all in integers.
// ---------------------------------------------------------------------------
module scm_chan_check
(
    input  scm_pkg::pix_t pix,
    input  scm_pkg::sum_t sum,
    input  scm_pkg::cnt_t count,
    input  scm_pkg::pix_t threshold,
    output logic          ok
);
    import scm_pkg::*;

    sum_t scaled;
    sum_t limit;
    sum_t delta;

    // 255*127 fits in 15 bits, so both products are exact
    assign scaled = SUM_W'(pix) * SUM_W'(count);
    assign limit  = SUM_W'(threshold) * SUM_W'(count);
    assign delta  = (scaled > sum) ? (scaled - sum) : (sum - scaled);
    assign ok     = (delta <= limit);

endmodule

[hdl/seed_color_threshold_mask.sv]
// ---------------------------------------------------------------------------
// Seed color threshold mask: top level
// Gathers the mean color around a seed point, then marks matching pixels.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one pixel per beat. kind 0 is a
//   gather beat: a pixel inside the square window of radius WINDOW_RADIUS
//   around (seed_row, seed_col) adds to the window sums; frame_start clears
//   the sums first. Gather beats give no output. kind 1 is a classify beat
//   and gives exactly one output beat (out_valid/out_stall) with mask_bit.
//   A classify beat's mask_bit is registered after the input stage. Throughput:
//   one beat per cycle unless the receiver stalls, set by the single input
//   stage feeding the single result register; gather beats keep going while
//   a result is held. On a receiver stall a classify beat waits in the input
//   stage and in_stall rises. Configuration (cfg_wr_en/cfg_index/cfg_data)
//   is the user's to write only while idle; the block does not enforce it.
//   Reset clears the sums and count, sets the seed to (0,0) and the threshold
//   to 50, and empties both stages. No clearing pass is needed.
// ---------------------------------------------------------------------------
`include "seed_color_threshold_mask_defines.svh"

module seed_color_threshold_mask
#(
    parameter int WINDOW_RADIUS = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_wr_en,
    input  scm_pkg::cfg_idx_t   cfg_index,
    input  scm_pkg::cfg_data_t  cfg_data,
    // pixel input
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic                frame_start,
    input  scm_pkg::coord_t     pixel_row,
    input  scm_pkg::coord_t     pixel_col,
    input  scm_pkg::pix_t       blue,
    input  scm_pkg::pix_t       green,
    input  scm_pkg::pix_t       red,
    // mask output
    output logic                out_valid,
    input  logic                out_stall,
    output logic                mask_bit
);
    import scm_pkg::*;

    // window side and count ceiling, worked out at elaboration
    localparam int SIDE      = 2 * WINDOW_RADIUS + 1;
    localparam int AREA      = SIDE * SIDE;
    localparam int COUNT_CAP = (AREA < COUNT_LIMIT) ? AREA : COUNT_LIMIT;
    localparam cnt_t CAP     = CNT_W'(COUNT_CAP);
    localparam coord_t RADIUS = COORD_W'(WINDOW_RADIUS);

    // ---- configuration registers ----
    coord_t seed_col_reg;
    coord_t seed_row_reg;
    pix_t   threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_col_reg  <= '0;
            seed_row_reg  <= '0;
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SEED_COL:  seed_col_reg  <= cfg_data;
                CFG_SEED_ROW:  seed_row_reg  <= cfg_data;
                CFG_THRESHOLD: threshold_reg <= cfg_data[PIX_W-1:0];
                default:       ;
            endcase
        end
    end

    // ---- input stage ----
    logic   s1_valid_reg;
    logic   s1_kind_reg;
    logic   s1_start_reg;
    coord_t s1_row_reg;
    coord_t s1_col_reg;
    pix_t   s1_blue_reg;
    pix_t   s1_green_reg;
    pix_t   s1_red_reg;

    logic   s1_valid_next;
    logic   s1_go;       // input stage hands its beat on this edge
    logic   in_fire;

    // a gather beat always retires; a classify beat needs room at the output
    assign s1_go    = s1_valid_reg &&
                      ((s1_kind_reg == KIND_GATHER) || !out_valid || !out_stall);
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg  <= kind;
            s1_start_reg <= frame_start;
            s1_row_reg   <= pixel_row;
            s1_col_reg   <= pixel_col;
            s1_blue_reg  <= blue;
            s1_green_reg <= green;
            s1_red_reg   <= red;
        end
    end

    // ---- window accumulation ----
    win_stats_t stats_reg;
    win_stats_t stats_next;
    win_stats_t stats_base;
    coord_t     row_dist;
    coord_t     col_dist;
    logic       in_window;

    assign row_dist  = (s1_row_reg > seed_row_reg) ? (s1_row_reg - seed_row_reg)
                                                   : (seed_row_reg - s1_row_reg);
    assign col_dist  = (s1_col_reg > seed_col_reg) ? (s1_col_reg - seed_col_reg)
                                                   : (seed_col_reg - s1_col_reg);
    assign in_window = (row_dist <= RADIUS) && (col_dist <= RADIUS);

    always_comb
    begin
        // frame_start clears before the add
        stats_base = s1_start_reg ? '0 : stats_reg;
        stats_next = stats_reg;
        if (s1_go && (s1_kind_reg == KIND_GATHER))
        begin
            stats_next = stats_base;
            if (in_window && (stats_base.count < CAP))
            begin
                stats_next.blue  = stats_base.blue  + SUM_W'(s1_blue_reg);
                stats_next.green = stats_base.green + SUM_W'(s1_green_reg);
                stats_next.red   = stats_base.red   + SUM_W'(s1_red_reg);
                stats_next.count = stats_base.count + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stats_reg <= '0;
        else
            stats_reg <= stats_next;
    end

    // ---- classification ----
    logic ok_blue;
    logic ok_green;
    logic ok_red;
    logic match;

    scm_chan_check u_chk_blue
    (
        .pix       (s1_blue_reg),
        .sum       (stats_reg.blue),
        .count     (stats_reg.count),
        .threshold (threshold_reg),
        .ok        (ok_blue)
    );

    scm_chan_check u_chk_green
    (
        .pix       (s1_green_reg),
        .sum       (stats_reg.green),
        .count     (stats_reg.count),
        .threshold (threshold_reg),
        .ok        (ok_green)
    );

    scm_chan_check u_chk_red
    (
        .pix       (s1_red_reg),
        .sum       (stats_reg.red),
        .count     (stats_reg.count),
        .threshold (threshold_reg),
        .ok        (ok_red)
    );

    // empty window never matches
    assign match = (stats_reg.count != '0) && ok_blue && ok_green && ok_red;

    // ---- result register ----
    logic out_valid_reg;
    logic out_valid_next;
    logic mask_bit_reg;
    logic cls_go;

    assign cls_go         = s1_go && (s1_kind_reg == KIND_CLASSIFY);
    assign out_valid_next = cls_go || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cls_go)
            mask_bit_reg <= match;
    end

    assign out_valid = out_valid_reg;
    assign mask_bit  = mask_bit_reg;

    // ---- assertions ----
    `SCM_ASSERT_NOW(a_count_cap, 1'b1, stats_reg.count <= CAP, "window count above cap")
    `SCM_ASSERT_NOW(a_stall_needs_beat, !s1_valid_reg, !in_stall, "stall with empty stage")
    `SCM_ASSERT_NEXT(a_empty_no_match, cls_go && (stats_reg.count == '0), !mask_bit, "empty window matched")
    `SCM_ASSERT_NEXT(a_start_clears, s1_go && !s1_kind_reg && s1_start_reg && !in_window, stats_reg.count == '0, "frame start did not clear")

endmodule
